// ===== rtl/gb3_pkg.sv =====
// gb3_pkg: shared types, codes and the kernel arithmetic of the 3x3 gaussian blur
// used by gb3_res_fifo and gaussian_blur_3x3_top; depends on nothing
package gb3_pkg;

  localparam logic [7:0] PIX_EDGE = 8'hFF;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [10:0] WIDTH_RESET  = 11'd640;
  localparam logic [11:0] HEIGHT_RESET = 12'd480;

  localparam int RES_DEPTH = 8;
  localparam int RES_PW    = 3;
  localparam int RES_CW    = 4;

  typedef struct packed {
    logic [7:0] top;
    logic [7:0] mid;
    logic [7:0] bot;
  } col_t;

  localparam col_t COL_EDGE = '{top: PIX_EDGE, mid: PIX_EDGE, bot: PIX_EDGE};

  typedef struct packed {
    logic [7:0] pixel;
    logic       eor;
    logic       eof;
    logic       eorun;
  } res_t;

  function automatic logic [7:0] blur(input col_t l, input col_t m, input col_t r);
    logic [11:0] s;
    s = 12'(l.top) + 12'(r.top) + 12'(l.bot) + 12'(r.bot)
      + (12'(m.top) << 1) + (12'(m.bot) << 1) + (12'(l.mid) << 1) + (12'(r.mid) << 1)
      + (12'(m.mid) << 2);
    return s[11:4];
  endfunction

endpackage

// ===== rtl/gb3_res_fifo.sv =====
// gb3_res_fifo: result queue taking up to two results per cycle, one out per transfer
// depends on gb3_pkg
module gb3_res_fifo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [1:0]                push_n_i,
  input  gb3_pkg::res_t             push0_i,
  input  gb3_pkg::res_t             push1_i,
  input  logic                      pop_i,
  output gb3_pkg::res_t             head_o,
  output logic                      vld_o,
  output logic [gb3_pkg::RES_CW-1:0] cnt_o
);

  gb3_pkg::res_t mem_q [gb3_pkg::RES_DEPTH];
  logic [gb3_pkg::RES_PW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [gb3_pkg::RES_CW-1:0] cnt_q, cnt_d;
  logic                       pop;

  assign vld_o  = (cnt_q != '0);
  assign pop    = pop_i && vld_o;
  assign head_o = mem_q[rptr_q];
  assign cnt_o  = cnt_q;

  always_comb begin
    wptr_d = wptr_q + gb3_pkg::RES_PW'(push_n_i);
    rptr_d = rptr_q + gb3_pkg::RES_PW'(pop);
    cnt_d  = cnt_q + gb3_pkg::RES_CW'(push_n_i) - gb3_pkg::RES_CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wptr_q] <= push0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wptr_q + gb3_pkg::RES_PW'(1)] <= push1_i;
    end
  end

endmodule

// ===== rtl/gaussian_blur_3x3_top.sv =====
// gaussian_blur_3x3_top: streaming 3x3 gaussian blur with two line stores
// depends on gb3_pkg and gb3_res_fifo
//
//  port group      direction  handshake              payload
//  input stream    in         in_valid_i/in_ready_o  action_i, pixel_in_i
//  result stream   out        out_valid_o/out_ready_i pixel_out_o, end_of_row_o,
//                                                     end_of_frame_o, end_of_run_o
//  register write  in         cfg_we_i               cfg_idx_i, cfg_data_i
//
//  one item per cycle while in_ready_o is high; the line stores are read at the input
//  transfer and written back in the cycle after, results enter the queue that cycle and
//  show the cycle after; a row end can give two results, so the result port paces there
//  reset clears counters, window and queue; line stores need no clearing pass
//  input stalls while the queue lacks room for two results beyond those in flight
module gaussian_blur_3x3_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [7:0]  pixel_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  pixel_out_o,
  output logic        end_of_row_o,
  output logic        end_of_frame_o,
  output logic        end_of_run_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [11:0] cfg_data_i
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int EW = (CW > 11) ? CW : 11;

  // configuration
  logic [10:0] width_q;
  logic [11:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= gb3_pkg::WIDTH_RESET;
      height_q <= gb3_pkg::HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gb3_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[10:0];
        gb3_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage 0: position, addresses
  logic [EW-1:0] w_ext;
  logic [CW-1:0] w_eff, c_full, fl_q, f1;
  logic [11:0]   h_eff, r, row_q, row_next;
  logic [AW-1:0] col_q, c, addr_a, addr_b;
  logic          acc, is_pix, last, flok, fb_valid;

  always_comb begin
    if (width_q == '0) begin
      w_ext = EW'(1);
    end else if (EW'(width_q) > EW'(MAX_WIDTH)) begin
      w_ext = EW'(MAX_WIDTH);
    end else begin
      w_ext = EW'(width_q);
    end
    w_eff    = w_ext[CW-1:0];
    h_eff    = (height_q == '0) ? 12'd1 : height_q;
    c_full   = (CW'(col_q) < w_eff) ? CW'(col_q) : w_eff - CW'(1);
    c        = c_full[AW-1:0];
    last     = (c_full == w_eff - CW'(1));
    r        = (row_q < h_eff) ? row_q : h_eff - 12'd1;
    row_next = ((13'(r) + 13'd1) >= 13'(h_eff)) ? 12'd0 : r + 12'd1;
    f1       = fl_q + CW'(1);
    flok     = (col_q == '0) && (row_q == '0) && (fl_q < w_eff);
    fb_valid = (f1 < w_eff);
    is_pix   = (action_i == gb3_pkg::ACT_PIXEL);
    addr_a   = is_pix ? c : fl_q[AW-1:0];
    addr_b   = fb_valid ? f1[AW-1:0] : fl_q[AW-1:0];
  end

  // stage 1 registers
  logic          s1_vld_q, s1_pix_q, s1_flok_q, s1_c0_q, s1_cge1_q, s1_last_q;
  logic          s1_rge1_q, s1_rge2_q, s1_hge2_q, s1_fge1_q, s1_fbv_q, s1_flast_q;
  logic          fwd_a_q, fwd_b_q;
  logic [7:0]    s1_px_q, wr_up_q, wr_mid_q;
  logic [AW-1:0] s1_addr_q;
  logic [7:0]    up_a_q, mid_a_q, up_b_q, mid_b_q;
  logic [7:0]    up_a, mid_a, up_b, mid_b;
  logic          s1_wr;

  logic [7:0] up_mem  [MAX_WIDTH];
  logic [7:0] mid_mem [MAX_WIDTH];

  logic [gb3_pkg::RES_CW-1:0] fifo_cnt;
  logic [gb3_pkg::RES_CW:0]   need;

  assign need       = {1'b0, fifo_cnt} + (s1_vld_q ? (gb3_pkg::RES_CW + 1)'(2) : '0)
                    + (gb3_pkg::RES_CW + 1)'(2);
  assign in_ready_o = (need <= (gb3_pkg::RES_CW + 1)'(gb3_pkg::RES_DEPTH));
  assign acc        = in_valid_i && in_ready_o;
  assign s1_wr      = s1_vld_q && s1_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      fl_q     <= '0;
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= acc;
      if (acc && is_pix) begin
        col_q <= last ? '0 : c + AW'(1);
        row_q <= last ? row_next : r;
        fl_q  <= '0;
      end else if (acc && flok) begin
        fl_q <= f1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_pix_q   <= is_pix;
      s1_flok_q  <= flok;
      s1_c0_q    <= (c_full == '0);
      s1_cge1_q  <= (c_full != '0);
      s1_last_q  <= last;
      s1_rge1_q  <= (r != '0);
      s1_rge2_q  <= (r > 12'd1);
      s1_hge2_q  <= (h_eff > 12'd1);
      s1_fge1_q  <= (fl_q != '0);
      s1_fbv_q   <= fb_valid;
      s1_flast_q <= (fl_q == w_eff - CW'(1));
      s1_px_q    <= pixel_in_i;
      s1_addr_q  <= addr_a;
      fwd_a_q    <= s1_wr && (addr_a == s1_addr_q);
      fwd_b_q    <= s1_wr && (addr_b == s1_addr_q);
      wr_up_q    <= mid_a;
      wr_mid_q   <= s1_px_q;
      up_a_q     <= up_mem[addr_a];
      mid_a_q    <= mid_mem[addr_a];
      up_b_q     <= up_mem[addr_b];
      mid_b_q    <= mid_mem[addr_b];
    end
    if (s1_wr) begin
      up_mem[s1_addr_q]  <= mid_a;
      mid_mem[s1_addr_q] <= s1_px_q;
    end
  end

  assign up_a  = fwd_a_q ? wr_up_q  : up_a_q;
  assign mid_a = fwd_a_q ? wr_mid_q : mid_a_q;
  assign up_b  = fwd_b_q ? wr_up_q  : up_b_q;
  assign mid_b = fwd_b_q ? wr_mid_q : mid_b_q;

  // stage 1: window and kernel
  gb3_pkg::col_t wa_q, wb_q, b_col, nw, fl_left, fl_midc, fl_right;
  logic [7:0]    fl_up_q, fl_mid_q;
  gb3_pkg::res_t res1, res2, resf, push0, push1;
  logic          p_r1, p_r2;
  logic [1:0]    push_n;

  always_comb begin
    b_col    = s1_c0_q ? gb3_pkg::COL_EDGE : wb_q;
    nw.top   = s1_rge2_q ? up_a : gb3_pkg::PIX_EDGE;
    nw.mid   = s1_rge1_q ? mid_a : gb3_pkg::PIX_EDGE;
    nw.bot   = s1_px_q;
    p_r1     = s1_rge1_q && s1_cge1_q;
    p_r2     = s1_rge1_q && s1_last_q;
    res1     = '{pixel: gb3_pkg::blur(wa_q, b_col, nw), eor: 1'b0, eof: 1'b0,
                 eorun: !p_r2};
    res2     = '{pixel: gb3_pkg::blur(b_col, nw, gb3_pkg::COL_EDGE), eor: 1'b1,
                 eof: 1'b0, eorun: 1'b1};
    fl_left  = gb3_pkg::COL_EDGE;
    if (s1_fge1_q) begin
      fl_left.top = s1_hge2_q ? fl_up_q : gb3_pkg::PIX_EDGE;
      fl_left.mid = fl_mid_q;
    end
    fl_midc     = gb3_pkg::COL_EDGE;
    fl_midc.top = s1_hge2_q ? up_a : gb3_pkg::PIX_EDGE;
    fl_midc.mid = mid_a;
    fl_right    = gb3_pkg::COL_EDGE;
    if (s1_fbv_q) begin
      fl_right.top = s1_hge2_q ? up_b : gb3_pkg::PIX_EDGE;
      fl_right.mid = mid_b;
    end
    resf = '{pixel: gb3_pkg::blur(fl_left, fl_midc, fl_right), eor: s1_flast_q,
             eof: s1_flast_q, eorun: 1'b1};
    push1 = res2;
    if (!s1_vld_q) begin
      push_n = 2'd0;
      push0  = resf;
    end else if (s1_pix_q) begin
      push_n = 2'(p_r1) + 2'(p_r2);
      push0  = p_r1 ? res1 : res2;
    end else begin
      push_n = s1_flok_q ? 2'd1 : 2'd0;
      push0  = resf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wa_q <= gb3_pkg::COL_EDGE;
      wb_q <= gb3_pkg::COL_EDGE;
    end else if (s1_wr) begin
      wa_q <= b_col;
      wb_q <= nw;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q && !s1_pix_q && s1_flok_q) begin
      fl_up_q  <= up_a;
      fl_mid_q <= mid_a;
    end
  end

  gb3_pkg::res_t head;

  gb3_res_fifo u_res_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .push0_i  (push0),
    .push1_i  (push1),
    .pop_i    (out_ready_i),
    .head_o   (head),
    .vld_o    (out_valid_o),
    .cnt_o    (fifo_cnt)
  );

  assign pixel_out_o    = head.pixel;
  assign end_of_row_o   = head.eor;
  assign end_of_frame_o = head.eof;
  assign end_of_run_o   = head.eorun;

  // checks
  a_room_for_stage1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q |-> (fifo_cnt <= gb3_pkg::RES_CW'(gb3_pkg::RES_DEPTH - 2)))
    else $error("result queue overrun possible");

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && is_pix && last && (row_next == '0)) |=> ((col_q == '0) && (row_q == '0)))
    else $error("counters not cleared at frame end");

  a_flush_from_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && !is_pix && flok) |-> ((col_q == '0) && (row_q == '0)))
    else $error("flush taken away from frame start");

  a_push_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!s1_vld_q) |-> (push_n == 2'd0))
    else $error("result pushed without an item in flight");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// testbench: checks gaussian_blur_3x3_top against an in-bench blur predictor on
// randomised frames, flush runs and register changes; depends on gb3_pkg and the rtl
module testbench;

  localparam int MAX_W  = 1024;
  localparam int SETTLE = 8;

  typedef struct packed {
    logic [7:0] top;
    logic [7:0] mid;
    logic [7:0] bot;
  } column3_t;

  typedef struct packed {
    logic       act;
    logic [7:0] px;
  } stream_item_t;

  localparam column3_t EDGE_COL = '{top: gb3_pkg::PIX_EDGE, mid: gb3_pkg::PIX_EDGE,
                                    bot: gb3_pkg::PIX_EDGE};

  logic        clk_i;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready_o;
  logic        action    = gb3_pkg::ACT_PIXEL;
  logic [7:0]  pixel     = '0;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  logic [7:0]  pixel_out_o;
  logic        end_of_row_o;
  logic        end_of_frame_o;
  logic        end_of_run_o;
  logic        cfg_we    = 1'b0;
  logic        cfg_idx   = gb3_pkg::REG_IMAGE_WIDTH;
  logic [11:0] cfg_data  = '0;

  // blur predictor state
  logic [7:0]    upper_row  [MAX_W];
  logic [7:0]    middle_row [MAX_W];
  column3_t      win_a, win_b;
  int unsigned   col_pos, row_pos, flush_pos;
  logic [10:0]   width_reg;
  logic [11:0]   height_reg;
  gb3_pkg::res_t expected_blurs[$];

  // stimulus bookkeeping
  stream_item_t stream_items[$];
  stream_item_t next_item;
  int unsigned  g_col, g_row, g_w, g_h, g_flushed, stim_cnt;
  bit           frame_done;
  int           mismatches = 0;

  int  tx_burst = 1, tx_gap = 0;
  int  rx_mode = 0, rx_left = 0, hold_left = 0;
  bit  hold_done = 1'b0;
  logic long_hold = 1'b0;
  gb3_pkg::res_t want;

  gaussian_blur_3x3_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .action_i       (action),
    .pixel_in_i     (pixel),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .pixel_out_o    (pixel_out_o),
    .end_of_row_o   (end_of_row_o),
    .end_of_frame_o (end_of_frame_o),
    .end_of_run_o   (end_of_run_o),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int unsigned cur_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_W) return MAX_W;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned cur_height();
    return (height_reg == 0) ? 1 : 32'(height_reg);
  endfunction

  function automatic logic [7:0] gauss_weigh(column3_t l, column3_t m, column3_t r);
    logic [11:0] acc;
    acc = 12'(l.top + r.top + l.bot + r.bot + 2 * (m.top + m.bot + l.mid + r.mid)
              + 4 * m.mid);
    return acc[11:4];
  endfunction

  task automatic compute_blur_results(input logic act, input logic [7:0] px);
    int unsigned   w, h, c, r, f, cn;
    int            n;
    column3_t      lft, mid, nxt;
    column3_t      cols[3];
    gb3_pkg::res_t fresh[2];
    n = 0;
    w = cur_width();
    h = cur_height();
    if (act == gb3_pkg::ACT_PIXEL) begin
      c = (col_pos < w) ? col_pos : w - 1;
      r = (row_pos < h) ? row_pos : h - 1;
      if (c == 0) win_b = EDGE_COL;
      lft = win_a;
      mid = win_b;
      nxt.top = (r >= 2) ? upper_row[c] : gb3_pkg::PIX_EDGE;
      nxt.mid = (r >= 1) ? middle_row[c] : gb3_pkg::PIX_EDGE;
      nxt.bot = px;
      upper_row[c]  = middle_row[c];
      middle_row[c] = px;
      if (r >= 1) begin
        if (c >= 1) begin
          fresh[n] = '{gauss_weigh(lft, mid, nxt), 1'b0, 1'b0, 1'b0};
          n++;
        end
        if (c == w - 1) begin
          fresh[n] = '{gauss_weigh(mid, nxt, EDGE_COL), 1'b1, 1'b0, 1'b0};
          n++;
        end
        if (n > 0) fresh[n - 1].eorun = 1'b1;
      end
      win_a = mid;
      win_b = nxt;
      if (c == w - 1) begin
        col_pos = 0;
        row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col_pos = c + 1;
        row_pos = r;
      end
      flush_pos = 0;
    end else if (col_pos == 0 && row_pos == 0 && flush_pos < w) begin
      // bottom row, one centre per flush
      f = flush_pos;
      for (int d = 0; d < 3; d++) begin
        cn = f + d;
        if (cn >= 1 && cn - 1 < w) begin
          cols[d].top = (h >= 2) ? upper_row[cn - 1] : gb3_pkg::PIX_EDGE;
          cols[d].mid = middle_row[cn - 1];
        end else begin
          cols[d].top = gb3_pkg::PIX_EDGE;
          cols[d].mid = gb3_pkg::PIX_EDGE;
        end
        cols[d].bot = gb3_pkg::PIX_EDGE;
      end
      fresh[0] = '{gauss_weigh(cols[0], cols[1], cols[2]), f == w - 1, f == w - 1, 1'b1};
      n = 1;
      flush_pos = f + 1;
    end
    for (int i = 0; i < n; i++) expected_blurs.insert(expected_blurs.size(), fresh[i]);
  endtask

  task automatic compare_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  // sender
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        compute_blur_results(action, pixel);
      end
      if (!in_valid || in_ready_o) begin
        if (tx_gap > 0 && !long_hold) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (stream_items.size() > 0) begin
          next_item = stream_items.pop_front();
          in_valid <= 1'b1;
          action   <= next_item.act;
          pixel    <= next_item.px;
          if (tx_burst > 1) begin
            tx_burst--;
          end else begin
            tx_burst = $urandom_range(1, 32);
            tx_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off once results are backing up
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      if (hold_left == 0) long_hold <= 1'b0;
      out_ready <= 1'b0;
    end else if (!hold_done && expected_blurs.size() >= 4 && stream_items.size() >= 32) begin
      hold_done = 1'b1;
      hold_left = 300;
      long_hold <= 1'b1;
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(8, 64);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        0: begin
          out_ready <= 1'b1;
        end
        1: begin
          out_ready <= 1'($urandom_range(0, 1));
        end
        2: begin
          out_ready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          out_ready <= (rx_left % 3 == 0);
        end
      endcase
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      if (expected_blurs.size() == 0) begin
        $error("unexpected result transfer: pixel_out %0d", pixel_out_o);
        mismatches++;
      end else begin
        want = expected_blurs.pop_front();
        compare_field("pixel_out", want.pixel, pixel_out_o);
        compare_field("end_of_row", 8'(want.eor), 8'(end_of_row_o));
        compare_field("end_of_frame", 8'(want.eof), 8'(end_of_frame_o));
        compare_field("end_of_run", 8'(want.eorun), 8'(end_of_run_o));
      end
    end
  end

  function automatic logic [7:0] rand_pix();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_pixel(input logic [7:0] px);
    int unsigned c, r;
    c = (g_col < g_w) ? g_col : g_w - 1;
    r = (g_row < g_h) ? g_row : g_h - 1;
    stream_items.insert(stream_items.size(), stream_item_t'{gb3_pkg::ACT_PIXEL, px});
    stim_cnt++;
    g_flushed = 0;
    if (c == g_w - 1) begin
      g_col      = 0;
      g_row      = (r + 1 >= g_h) ? 0 : r + 1;
      frame_done = (g_row == 0);
    end else begin
      g_col      = c + 1;
      g_row      = r;
      frame_done = 1'b0;
    end
  endtask

  task automatic push_flush();
    stream_items.insert(stream_items.size(),
                        stream_item_t'{gb3_pkg::ACT_FLUSH, 8'($urandom)});
    if (g_col == 0 && g_row == 0 && frame_done && g_flushed < g_w) begin
      g_flushed++;
      stim_cnt++;
    end
  endtask

  task automatic flush_bottom(input int extra);
    if (frame_done) begin
      repeat (g_w) push_flush();
      repeat (extra) push_flush();
    end
  endtask

  task automatic finish_frame();
    do begin
      push_pixel(rand_pix());
      if (!(g_col == 0 && g_row == 0) && $urandom_range(0, 15) == 0) push_flush();
    end while (!(g_col == 0 && g_row == 0));
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (stream_items.size() != 0 || in_valid || expected_blurs.size() != 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic set_size(input logic [11:0] wd, input logic [11:0] hd);
    wait_idle();
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= gb3_pkg::REG_IMAGE_WIDTH;
    cfg_data <= wd;
    @(posedge clk_i);
    cfg_idx  <= gb3_pkg::REG_IMAGE_HEIGHT;
    cfg_data <= hd;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    width_reg  = wd[10:0];
    height_reg = hd;
    g_w        = cur_width();
    g_h        = cur_height();
    frame_done = 1'b0;
  endtask

  initial begin
    int unsigned w, h, k;
    win_a      = EDGE_COL;
    win_b      = EDGE_COL;
    col_pos    = 0;
    row_pos    = 0;
    flush_pos  = 0;
    width_reg  = gb3_pkg::WIDTH_RESET;
    height_reg = gb3_pkg::HEIGHT_RESET;
    g_w        = cur_width();
    g_h        = cur_height();
    g_col      = 0;
    g_row      = 0;
    g_flushed  = 0;
    frame_done = 1'b0;
    stim_cnt   = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset size: row 0 gives nothing, flush inside a frame is ignored
    push_pixel(8'h00);
    push_pixel(8'hFF);
    push_pixel(8'h5A);
    push_flush();
    push_pixel(8'hA5);
    push_pixel(8'hFF);
    // shrink below the column count, which becomes the last column
    set_size(12'd3, 12'd3);
    push_pixel(8'h00);
    push_pixel(8'hFF);
    push_pixel(8'h00);
    push_pixel(8'hFF);
    push_pixel(8'hFF);
    push_pixel(8'h00);
    push_pixel(8'h0F);
    flush_bottom(2);
    // widest and tallest settings, then the smallest mid-frame
    set_size(12'hFFF, 12'hFFF);
    push_pixel(8'hF0);
    push_pixel(8'h3C);
    push_pixel(8'hC3);
    set_size(12'd0, 12'd0);
    push_pixel(8'h81);
    flush_bottom(1);

    stim_cnt = 0;
    while (stim_cnt < 800) begin
      w = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      if ($urandom_range(0, 19) == 0) w = 0;
      h = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
      if ($urandom_range(0, 19) == 0) h = 0;
      set_size({1'($urandom), 11'(w)}, 12'(h));
      if ($urandom_range(0, 9) >= 7 && g_w * g_h > 1) begin
        // registers change part way through the frame
        k = $urandom_range(1, g_w * g_h - 1);
        repeat (k) push_pixel(rand_pix());
        set_size({1'($urandom), 11'($urandom_range(0, g_w))}, 12'($urandom_range(0, g_h + 3)));
      end
      finish_frame();
      if ($urandom_range(0, 9) != 0) begin
        flush_bottom(($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
